// ===== sv/masked_byte_pattern_scanner_top_defines.svh =====
// assertion macros used by the bound checker in mbps_checker.sv
`ifndef MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCANNER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mbps_pkg.sv =====
`timescale 1ns / 1ps

package mbps_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PATTERN_0    = 3'd0;
    localparam logic [2:0] REG_PATTERN_1    = 3'd1;
    localparam logic [2:0] REG_PATTERN_2    = 3'd2;
    localparam logic [2:0] REG_PATTERN_3    = 3'd3;
    localparam logic [2:0] REG_CARE_MASK    = 3'd4;
    localparam logic [2:0] REG_PATTERN_LEN  = 3'd5;
    localparam logic [2:0] REG_RESOLVE_MODE = 3'd6;
    localparam logic [2:0] REG_FIELD_OFFSET = 3'd7;

    // resolve modes
    localparam logic [1:0] MODE_REL32 = 2'd0;

    localparam logic [7:0] CALL_OPCODE = 8'hE8;
    localparam logic [5:0] CALL_OFFSET = 6'd1;
    localparam logic [5:0] MAX_PATTERN = 6'd32;
    localparam logic [5:0] PATTERN_RESET_LEN = 6'd1;
    localparam int         SPAN_W = 7;

    // pattern placement derived from the configuration
    typedef struct packed {
        logic              rel;
        logic [5:0]        off;
        logic [SPAN_W-1:0] span;
    } align_t;

endpackage

// ===== sv/mbps_config.sv =====
`timescale 1ns / 1ps

module mbps_config #(
    parameter int WINDOW_BYTES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [63:0]               cfg_data,
    output mbps_pkg::align_t          align,
    output logic [8*WINDOW_BYTES-1:0] expected,
    output logic [WINDOW_BYTES-1:0]   care
);

    localparam int KW = $clog2(WINDOW_BYTES + 68) + 1;

    logic [255:0] pattern_reg;
    logic [31:0]  care_mask_reg;
    logic [5:0]   pattern_length_reg;
    logic [1:0]   resolve_mode_reg;
    logic [5:0]   field_offset_reg;

    logic [5:0]                 len;
    logic                       call_pat;
    logic [mbps_pkg::SPAN_W-1:0] need_rel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg        <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= mbps_pkg::PATTERN_RESET_LEN;
            resolve_mode_reg   <= '0;
            field_offset_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbps_pkg::REG_PATTERN_0:    pattern_reg[63:0]    <= cfg_data;
                mbps_pkg::REG_PATTERN_1:    pattern_reg[127:64]  <= cfg_data;
                mbps_pkg::REG_PATTERN_2:    pattern_reg[191:128] <= cfg_data;
                mbps_pkg::REG_PATTERN_3:    pattern_reg[255:192] <= cfg_data;
                mbps_pkg::REG_CARE_MASK:    care_mask_reg        <= cfg_data[31:0];
                mbps_pkg::REG_PATTERN_LEN:  pattern_length_reg   <= cfg_data[5:0];
                mbps_pkg::REG_RESOLVE_MODE: resolve_mode_reg     <= cfg_data[1:0];
                mbps_pkg::REG_FIELD_OFFSET: field_offset_reg     <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign len = (pattern_length_reg > mbps_pkg::MAX_PATTERN) ? mbps_pkg::MAX_PATTERN
                                                              : pattern_length_reg;
    assign call_pat = (pattern_reg[7:0] == mbps_pkg::CALL_OPCODE);

    always_comb
    begin
        align.rel = call_pat || (resolve_mode_reg == mbps_pkg::MODE_REL32);
        align.off = call_pat ? mbps_pkg::CALL_OFFSET : field_offset_reg;
        need_rel  = mbps_pkg::SPAN_W'(align.off) + mbps_pkg::SPAN_W'(4);
        align.span = mbps_pkg::SPAN_W'(len);
        if (align.rel && (need_rel > align.span))
        begin
            align.span = need_rel;
        end
        if (align.span == '0)
        begin
            align.span = mbps_pkg::SPAN_W'(1);
        end
    end

    // window slot i holds buffer byte s + (span-1-i): lay the pattern out reversed
    always_comb
    begin
        logic [KW-1:0] kk;
        expected = '0;
        care     = '0;
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            kk = KW'(align.span) - KW'(1) - KW'(i);
            if (kk < KW'(len))
            begin
                expected[8*i +: 8] = pattern_reg[8*kk[4:0] +: 8];
                care[i]            = care_mask_reg[kk[4:0]];
            end
        end
    end

endmodule

// ===== sv/mbps_scan.sv =====
`timescale 1ns / 1ps

module mbps_scan #(
    parameter int WINDOW_BYTES = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,
    input  mbps_pkg::align_t          align,
    input  logic [8*WINDOW_BYTES-1:0] expected,
    input  logic [WINDOW_BYTES-1:0]   care,
    output logic                      res_valid,
    output logic                      res_found,
    output logic [31:0]               res_position,
    output logic [31:0]               res_address
);

    localparam int FW = $clog2(WINDOW_BYTES + 1);
    localparam int CW = FW + mbps_pkg::SPAN_W;
    localparam int KW = $clog2(WINDOW_BYTES + 68) + 1;

    logic [8*WINDOW_BYTES-1:0] window_reg, window_next, shifted_in;
    logic [FW-1:0]             fill_reg, fill_next, fill_inc;
    logic [31:0]               count_reg, count_next;
    logic                      found_reg, found_next;

    logic [WINDOW_BYTES-1:0]   byte_ok;
    logic                      take;
    logic [KW-1:0]             disp_low;
    logic [8*WINDOW_BYTES-1:0] disp_shift;
    logic [31:0]               disp, position, address;

    assign shifted_in = {window_reg[8*(WINDOW_BYTES-1)-1:0], data_byte};
    assign fill_inc   = (fill_reg == FW'(WINDOW_BYTES)) ? fill_reg : fill_reg + FW'(1);

    always_comb
    begin
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            byte_ok[i] = !care[i] || (shifted_in[8*i +: 8] == expected[8*i +: 8]);
        end
    end

    assign take = (&byte_ok) && (CW'(align.span) <= CW'(fill_inc));

    // displacement bytes sit at slots span-1-off down to span-4-off
    assign disp_low   = KW'(align.span) - KW'(4) - KW'(align.off);
    assign disp_shift = shifted_in >> {disp_low, 3'b000};
    assign disp       = {disp_shift[7:0], disp_shift[15:8], disp_shift[23:16],
                         disp_shift[31:24]};
    assign position   = count_reg - 32'(align.span) + 32'd1;
    assign address    = position + 32'(align.off) + (align.rel ? disp + 32'd4 : 32'd0);

    always_comb
    begin
        window_next  = window_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        found_next   = found_reg;
        res_valid    = 1'b0;
        res_found    = 1'b0;
        res_position = '0;
        res_address  = '0;
        if (step)
        begin
            if (!found_reg)
            begin
                window_next = shifted_in;
                fill_next   = fill_inc;
                count_next  = count_reg + 32'd1;
                if (take)
                begin
                    found_next   = 1'b1;
                    res_valid    = 1'b1;
                    res_found    = 1'b1;
                    res_position = position;
                    res_address  = address;
                end
            end
            if (last_byte)
            begin
                if (!found_reg && !take)
                begin
                    res_valid = 1'b1;
                end
                window_next = '0;
                fill_next   = '0;
                count_next  = '0;
                found_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            count_reg  <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            found_reg  <= found_next;
        end
    end

endmodule

// ===== sv/masked_byte_pattern_scanner_top.sv =====
`timescale 1ns / 1ps
// result path: input register (s1) to result register (out), which drives m_tvalid
// throughput: one byte per cycle while m_tready stays high; the window compare,
// displacement add and result register all sit in a single stage
// reset (rst_n low, asynchronous): registers to defaults, window and stream state
// cleared, no transaction pending; stream state also restarts after each last byte
module masked_byte_pattern_scanner_top #(
    parameter int WINDOW_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] match_position, [63:32] resolved_address
    output logic        m_tuser,   // found
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic s1_last_reg;
    logic s1_adv;

    logic out_valid_reg, out_valid_next;
    logic out_found_reg;
    logic [31:0] out_pos_reg, out_addr_reg;

    mbps_pkg::align_t          align;
    logic [8*WINDOW_BYTES-1:0] expected;
    logic [WINDOW_BYTES-1:0]   care;
    logic                      res_valid, res_found;
    logic [31:0]               res_position, res_address;

    mbps_config #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_config (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .align    (align),
        .expected (expected),
        .care     (care)
    );

    mbps_scan #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (s1_adv),
        .data_byte   (s1_byte_reg),
        .last_byte   (s1_last_reg),
        .align       (align),
        .expected    (expected),
        .care        (care),
        .res_valid   (res_valid),
        .res_found   (res_found),
        .res_position(res_position),
        .res_address (res_address)
    );

    // input stage moves on whenever the result register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next  = (s_tvalid && s_tready) || (s1_valid_reg && !s1_adv);
        out_valid_next = out_valid_reg && !m_tready;
        if (s1_adv && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (s1_adv && res_valid)
        begin
            out_found_reg <= res_found;
            out_pos_reg   <= res_position;
            out_addr_reg  <= res_address;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_addr_reg, out_pos_reg};
    assign m_tuser  = out_found_reg;

endmodule

// ===== sv/mbps_checker.sv =====
`timescale 1ns / 1ps
`include "masked_byte_pattern_scanner_top_defines.svh"

module mbps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // a waiting result must not change under the consumer
    `MBPS_ASSERT_NEXT(a_result_held, clk, rst_n, m_tvalid && !m_tready,
                      m_tvalid && $stable(m_tdata) && $stable(m_tuser),
                      "result changed while stalled")

    // a not-found transaction carries zero position and address
    `MBPS_ASSERT_NOW(a_not_found_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == 64'd0,
                     "not-found result has non-zero payload")

    // with the result register empty the input side never stalls
    `MBPS_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready,
                     "input stalled with no result pending")

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

// ===== tb/sv/masked_byte_pattern_scanner_checker.sv =====
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_checker #(
    parameter int WINDOW_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [31:0] match_position, [63:32] resolved_address
    input  logic        m_tuser,   // found
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          pending_results,
    output int          mismatches,
    output int          matches_seen,
    output int          misses_seen
);

    typedef struct packed {
        logic        hit;
        logic [31:0] position;
        logic [31:0] address;
    } scan_result_t;

    // register copies
    logic [63:0] pattern_word [4];
    logic [31:0] care_bits;
    logic [5:0]  pattern_len;
    logic [1:0]  resolve_sel;
    logic [5:0]  field_off;

    // stream state
    logic [7:0]  window_bytes [WINDOW_BYTES];
    logic [31:0] next_index;
    logic        hit_taken;
    int          fill_level;

    scan_result_t awaited_results [$];
    scan_result_t want;
    int bad_count;
    int hit_count;
    int miss_count;

    function automatic logic [7:0] pattern_byte(input int k);
        if (k >= 32)
        begin
            return 8'h00;
        end
        return pattern_word[k / 8][(k % 8) * 8 +: 8];
    endfunction

    task automatic restart_stream();
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            window_bytes[i] = 8'h00;
        end
        next_index = '0;
        hit_taken = 1'b0;
        fill_level = 0;
    endtask

    task automatic scan_byte(input logic [7:0] value, input logic closing);
        int len;
        int off;
        int span;
        logic rel;
        logic hit;
        logic [31:0] newest;
        logic [31:0] start;
        logic [31:0] disp;
        logic [31:0] addr;
        scan_result_t item;
        if (!hit_taken)
        begin
            newest = next_index;
            for (int i = WINDOW_BYTES - 1; i > 0; i--)
            begin
                window_bytes[i] = window_bytes[i - 1];
            end
            window_bytes[0] = value;
            if (fill_level < WINDOW_BYTES)
            begin
                fill_level++;
            end
            next_index = next_index + 32'd1;

            len = (pattern_len > mbps_pkg::MAX_PATTERN) ? int'(mbps_pkg::MAX_PATTERN)
                                                        : int'(pattern_len);
            // a call opcode in front forces the rel32 form at offset one
            rel = (pattern_byte(0) == mbps_pkg::CALL_OPCODE) ||
                  (resolve_sel == mbps_pkg::MODE_REL32);
            off = (pattern_byte(0) == mbps_pkg::CALL_OPCODE) ? int'(mbps_pkg::CALL_OFFSET)
                                                             : int'(field_off);
            span = len;
            if (rel && off + 4 > span)
            begin
                span = off + 4;
            end
            if (span == 0)
            begin
                span = 1;
            end

            if (span <= fill_level)
            begin
                start = newest - 32'(span - 1);
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                begin
                    if (care_bits[k] && window_bytes[span - 1 - k] != pattern_byte(k))
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    addr = start + 32'(off);
                    if (rel)
                    begin
                        disp = {window_bytes[span - 4 - off], window_bytes[span - 3 - off],
                                window_bytes[span - 2 - off], window_bytes[span - 1 - off]};
                        addr = addr + disp + 32'd4;
                    end
                    item = '{hit: 1'b1, position: start, address: addr};
                    awaited_results.insert(awaited_results.size(), item);
                    hit_taken = 1'b1;
                end
            end
        end

        if (closing)
        begin
            if (!hit_taken)
            begin
                item = '{hit: 1'b0, position: '0, address: '0};
                awaited_results.insert(awaited_results.size(), item);
            end
            restart_stream();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                pattern_word[r] = '0;
            end
            care_bits = '0;
            pattern_len = mbps_pkg::PATTERN_RESET_LEN;
            resolve_sel = mbps_pkg::MODE_REL32;
            field_off = '0;
            restart_stream();
            awaited_results.delete();
            bad_count = 0;
            hit_count = 0;
            miss_count = 0;
            pending_results <= 0;
            mismatches <= 0;
            matches_seen <= 0;
            misses_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mbps_pkg::REG_PATTERN_0:    pattern_word[0] = cfg_data;
                    mbps_pkg::REG_PATTERN_1:    pattern_word[1] = cfg_data;
                    mbps_pkg::REG_PATTERN_2:    pattern_word[2] = cfg_data;
                    mbps_pkg::REG_PATTERN_3:    pattern_word[3] = cfg_data;
                    mbps_pkg::REG_CARE_MASK:    care_bits = cfg_data[31:0];
                    mbps_pkg::REG_PATTERN_LEN:  pattern_len = cfg_data[5:0];
                    mbps_pkg::REG_RESOLVE_MODE: resolve_sel = cfg_data[1:0];
                    mbps_pkg::REG_FIELD_OFFSET: field_off = cfg_data[5:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
            end

            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                    begin
                        $display("%0t: unexpected result transaction found=%0b pos=%h addr=%h",
                                 $realtime, m_tuser, m_tdata[31:0], m_tdata[63:32]);
                    end
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.hit)
                    begin
                        hit_count++;
                    end
                    else
                    begin
                        miss_count++;
                    end
                    if (m_tuser !== want.hit || m_tdata[31:0] !== want.position ||
                        m_tdata[63:32] !== want.address)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                        begin
                            $display("%0t: mismatch expected found=%0b pos=%h addr=%h,",
                                     $realtime, want.hit, want.position, want.address);
                            $display("    got found=%0b pos=%h addr=%h",
                                     m_tuser, m_tdata[31:0], m_tdata[63:32]);
                        end
                    end
                end
            end

            pending_results <= awaited_results.size();
            mismatches <= bad_count;
            matches_seen <= hit_count;
            misses_seen <= miss_count;
        end
    end

endmodule

// ===== tb/sv/masked_byte_pattern_scanner_top_test.sv =====
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_top_test;

    localparam int WINDOW_BYTES   = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 12;
    localparam int PHASE_BYTES    = 66;

    // resolve modes besides rel32
    localparam logic [1:0] MODE_POS_OFFSET = 2'd1;
    localparam logic [1:0] MODE_RAW_OFFSET = 2'd2;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    int pending_results;
    int mismatches;
    int matches_seen;
    int misses_seen;

    int tx_idle_pct = 24;
    int rx_idle_pct = 74;
    int hold_seq = 0;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int buffers_sent = 0;
    int setups_loaded = 0;

    // register values the next load writes
    logic [63:0] cur_pat [4];
    logic [31:0] cur_care;
    logic [5:0]  cur_len;
    logic [1:0]  cur_mode;
    logic [5:0]  cur_off;

    masked_byte_pattern_scanner_top #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    masked_byte_pattern_scanner_checker #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pending_results(pending_results),
        .mismatches     (mismatches),
        .matches_seen   (matches_seen),
        .misses_seen    (misses_seen)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // result side: random back-pressure, plus one long hold when asked
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, giving up", $realtime, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic closing);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        s_tlast <= closing;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (closing)
        begin
            buffers_sent++;
        end
    endtask

    // wait until every result is out and nothing is left in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setup();
        logic [63:0] word [8];
        logic [63:0] hi;
        hi = ($urandom_range(1) != 0) ? {$urandom, $urandom} : '0;
        word[mbps_pkg::REG_PATTERN_0]    = cur_pat[0];
        word[mbps_pkg::REG_PATTERN_1]    = cur_pat[1];
        word[mbps_pkg::REG_PATTERN_2]    = cur_pat[2];
        word[mbps_pkg::REG_PATTERN_3]    = cur_pat[3];
        // narrow registers get stray upper bits now and then
        word[mbps_pkg::REG_CARE_MASK]    = {hi[63:32], cur_care};
        word[mbps_pkg::REG_PATTERN_LEN]  = {hi[63:6], cur_len};
        word[mbps_pkg::REG_RESOLVE_MODE] = {hi[63:2], cur_mode};
        word[mbps_pkg::REG_FIELD_OFFSET] = {hi[63:6], cur_off};
        for (int r = mbps_pkg::REG_PATTERN_0; r <= mbps_pkg::REG_FIELD_OFFSET; r++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(r);
            cfg_data <= word[r];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        setups_loaded++;
    endtask

    task automatic pick_setup();
        for (int r = 0; r < 4; r++)
        begin
            cur_pat[r] = {$urandom, $urandom};
        end
        if ($urandom_range(5) == 0)
        begin
            cur_pat[0][7:0] = mbps_pkg::CALL_OPCODE;
        end
        case ($urandom_range(3))
            0: cur_care = '1;
            1: cur_care = '0;
            2: cur_care = $urandom;
            default: cur_care = $urandom & $urandom;
        endcase
        case ($urandom_range(9))
            0: cur_len = '0;
            1: cur_len = mbps_pkg::MAX_PATTERN;
            2: cur_len = 6'($urandom_range(33, 63));
            default: cur_len = 6'($urandom_range(1, 10));
        endcase
        cur_mode = 2'($urandom_range(3));
        cur_off = ($urandom_range(4) == 0) ? 6'($urandom_range(50, 63)) : 6'($urandom_range(12));
    endtask

    // random bytes, often with the pattern planted somewhere inside
    task automatic send_buffer(input int nbytes);
        logic [7:0] frame [];
        int elen;
        int need;
        int pos;
        elen = (cur_len > mbps_pkg::MAX_PATTERN) ? int'(mbps_pkg::MAX_PATTERN) : int'(cur_len);
        need = elen;
        if (cur_pat[0][7:0] == mbps_pkg::CALL_OPCODE)
        begin
            need = (need > int'(mbps_pkg::CALL_OFFSET) + 4) ? need
                                                            : int'(mbps_pkg::CALL_OFFSET) + 4;
        end
        else if (cur_mode == mbps_pkg::MODE_REL32)
        begin
            need = (need > int'(cur_off) + 4) ? need : int'(cur_off) + 4;
        end
        frame = new[nbytes];
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(9) < 3)
            begin
                frame[i] = cur_pat[$urandom_range(3)][$urandom_range(7) * 8 +: 8];
            end
            else
            begin
                frame[i] = 8'($urandom);
            end
        end
        if ($urandom_range(3) != 0)
        begin
            if (need <= nbytes && $urandom_range(3) != 0)
            begin
                pos = $urandom_range(nbytes - need);
            end
            else
            begin
                pos = $urandom_range(nbytes - 1);
            end
            for (int k = 0; k < elen && pos + k < nbytes; k++)
            begin
                if (cur_care[k])
                begin
                    frame[pos + k] = cur_pat[k / 8][(k % 8) * 8 +: 8];
                end
            end
        end
        for (int i = 0; i < nbytes; i++)
        begin
            push_byte(frame[i], i == nbytes - 1);
        end
    endtask

    initial
    begin
        int left;
        int n;
        for (int r = 0; r < 4; r++)
        begin
            cur_pat[r] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rel32 at offset zero, match as soon as four bytes are in
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b1);
        // too short for the displacement
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b1);

        // call opcode overrides mode and offset; bytes after the hit are dropped
        settle();
        cur_pat[0] = {56'h0, mbps_pkg::CALL_OPCODE};
        cur_care = 32'h1;
        cur_len = 6'd1;
        cur_mode = MODE_RAW_OFFSET;
        cur_off = 6'd40;
        load_setup();
        push_byte(8'h11, 1'b0);
        push_byte(mbps_pkg::CALL_OPCODE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(mbps_pkg::CALL_OPCODE, 1'b1);

        // empty pattern hits at once, on the closing byte
        settle();
        cur_pat[0] = '0;
        cur_care = '0;
        cur_len = '0;
        cur_mode = MODE_POS_OFFSET;
        cur_off = 6'd63;
        load_setup();
        push_byte(8'hFF, 1'b1);

        // displacement lies beyond the window, never taken
        settle();
        cur_len = 6'd1;
        cur_mode = mbps_pkg::MODE_REL32;
        cur_off = 6'd61;
        load_setup();
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);

        // unused mode with a plain pattern
        settle();
        cur_pat[0] = {56'h0, 8'h3C};
        cur_care = '1;
        cur_mode = MODE_UNUSED;
        cur_off = 6'd2;
        load_setup();
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            tx_idle_pct = (ph < PHASES / 3) ? 24 : (ph < 2 * PHASES / 3) ? 74 : 0;
            rx_idle_pct = (ph < PHASES / 3) ? 74 : (ph < 2 * PHASES / 3) ? 24 : 0;
            pick_setup();
            load_setup();
            if (ph == 2 * PHASES / 3)
            begin
                // long receiver hold with short buffers so results back up
                hold_seq++;
            end
            left = PHASE_BYTES;
            while (left > 0)
            begin
                if (ph == 2 * PHASES / 3)
                begin
                    n = $urandom_range(1, 4);
                end
                else if ($urandom_range(7) == 0)
                begin
                    n = $urandom_range(WINDOW_BYTES + 1, 100);
                end
                else
                begin
                    n = $urandom_range(1, 36);
                end
                send_buffer(n);
                left -= n;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d bytes in %0d buffers over %0d register settings",
                 bytes_sent, buffers_sent, setups_loaded);
        $display("checked %0d matches and %0d not-found results, %0d mismatches",
                 matches_seen, misses_seen, mismatches);
        if (mismatches == 0 && pending_results == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_config.sv
sv/mbps_scan.sv
sv/masked_byte_pattern_scanner_top.sv
sv/mbps_checker.sv
tb/sv/masked_byte_pattern_scanner_checker.sv
tb/sv/masked_byte_pattern_scanner_top_test.sv
